[hw/rtl/led_pattern_sequencer_defines.svh]
// ---------------------------------------------------------------------------
// LED pattern sequencer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_PATTERN_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led_pattern_sequencer: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("led_pattern_sequencer: next-cycle check failed");

`endif

[hw/rtl/lps_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LED pattern sequencer package
// Codes, timing constants, request types and the blink pattern ROM.
// ---------------------------------------------------------------------------
package lps_pkg;

    localparam int TICK_MS          = 1;
    localparam int PATTERN_SEGMENTS = 12;
    localparam int SEG_W            = $clog2(PATTERN_SEGMENTS);
    localparam int SEG_IDX_W        = SEG_W + 1;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SELECT = 2'd1;
    localparam logic [1:0] KIND_DIM    = 2'd2;

    localparam logic [3:0] PAT_OFF = 4'd0;

    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [15:0] DIM_RESET    = 16'd475;
    localparam logic [15:0] OFF_RESET    = 16'd501;
    localparam logic [15:0] CMP_FULL_ON  = 16'd0;
    localparam logic [15:0] CMP_MAX      = 16'hFFFF;
    // Reciprocal of five scaled by two to the 22nd, rounded up.
    localparam logic [19:0] DIV5_RECIP  = 20'd838861;

    localparam logic [15:0] T_NONE  = 16'd0;
    localparam logic [15:0] T_1HZ   = 16'(500 / TICK_MS);
    localparam logic [15:0] T_2HZ   = 16'(250 / TICK_MS);
    localparam logic [15:0] T_4HZ   = 16'(125 / TICK_MS);
    localparam logic [15:0] T_BLIP  = 16'(20 / TICK_MS);
    localparam logic [15:0] T_BOFF  = 16'(200 / TICK_MS);
    localparam logic [15:0] T_GAP   = 16'(200 / TICK_MS);
    localparam logic [15:0] T_PAUSE = 16'(1500 / TICK_MS);
    localparam logic [15:0] T_SLOW  = 16'(5000 / TICK_MS);

    localparam logic [SEG_IDX_W-1:0] SEG_LIMIT = SEG_IDX_W'(PATTERN_SEGMENTS);

    typedef struct packed {
        logic        on;
        logic [15:0] ticks;
    } t_seg;

    typedef struct packed {
        logic        tick;
        logic        sel;
        logic [3:0]  pattern;
        logic [15:0] now;
    } t_led_cmd;

    localparam t_seg SEG_STOP = '{on: 1'b0, ticks: T_NONE};

    function automatic t_seg mk_seg(input logic on, input logic [15:0] ticks);
        t_seg r;
        r.on    = on;
        r.ticks = ticks;
        return r;
    endfunction

    // Blink pattern ROM. A zero-time segment ends the pattern: lit means
    // repeat from the start, dark means stop. Indexes past the table stop.
    function automatic t_seg seg_rom(input logic [3:0] p, input logic [SEG_IDX_W-1:0] s);
        t_seg r;
        r = SEG_STOP;
        if (s < SEG_LIMIT) begin
            case (p)
                4'd0: r = mk_seg(1'b0, T_NONE);
                4'd1: r = mk_seg(1'b1, T_NONE);
                4'd2: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_1HZ);
                        1: r = mk_seg(1'b0, T_1HZ);
                        2: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd3: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_2HZ);
                        1: r = mk_seg(1'b0, T_2HZ);
                        2: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd4: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_4HZ);
                        1: r = mk_seg(1'b0, T_4HZ);
                        2: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd5: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd6: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_PAUSE);
                        2: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd7: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_GAP);
                        2: r = mk_seg(1'b1, T_BLIP);
                        3: r = mk_seg(1'b0, T_PAUSE);
                        4: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd8: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_GAP);
                        2: r = mk_seg(1'b1, T_BLIP);
                        3: r = mk_seg(1'b0, T_GAP);
                        4: r = mk_seg(1'b1, T_BLIP);
                        5: r = mk_seg(1'b0, T_PAUSE);
                        6: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd9: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_GAP);
                        2: r = mk_seg(1'b1, T_BLIP);
                        3: r = mk_seg(1'b0, T_GAP);
                        4: r = mk_seg(1'b1, T_BLIP);
                        5: r = mk_seg(1'b0, T_GAP);
                        6: r = mk_seg(1'b1, T_BLIP);
                        7: r = mk_seg(1'b0, T_PAUSE);
                        8: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd10: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_GAP);
                        1: r = mk_seg(1'b0, T_BOFF);
                        2: r = mk_seg(1'b1, T_PAUSE);
                        3: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd11: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_GAP);
                        1: r = mk_seg(1'b0, T_BOFF);
                        2: r = mk_seg(1'b1, T_GAP);
                        3: r = mk_seg(1'b0, T_BOFF);
                        4: r = mk_seg(1'b1, T_PAUSE);
                        5: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd12: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_GAP);
                        1: r = mk_seg(1'b0, T_BOFF);
                        2: r = mk_seg(1'b1, T_GAP);
                        3: r = mk_seg(1'b0, T_BOFF);
                        4: r = mk_seg(1'b1, T_GAP);
                        5: r = mk_seg(1'b0, T_BOFF);
                        6: r = mk_seg(1'b1, T_PAUSE);
                        7: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd13: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_GAP);
                        1: r = mk_seg(1'b0, T_BOFF);
                        2: r = mk_seg(1'b1, T_GAP);
                        3: r = mk_seg(1'b0, T_BOFF);
                        4: r = mk_seg(1'b1, T_GAP);
                        5: r = mk_seg(1'b0, T_BOFF);
                        6: r = mk_seg(1'b1, T_GAP);
                        7: r = mk_seg(1'b0, T_BOFF);
                        8: r = mk_seg(1'b1, T_PAUSE);
                        9: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd14: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_SLOW);
                        2: r = mk_seg(1'b1, T_NONE);
                        default: r = SEG_STOP;
                    endcase
                end
                4'd15: begin
                    case (s[SEG_W-1:0])
                        0: r = mk_seg(1'b1, T_BLIP);
                        1: r = mk_seg(1'b0, T_GAP);
                        2: r = mk_seg(1'b1, T_BLIP);
                        3: r = mk_seg(1'b0, T_GAP);
                        4: r = mk_seg(1'b1, T_BLIP);
                        5: r = mk_seg(1'b0, T_GAP);
                        6: r = mk_seg(1'b1, T_BLIP);
                        7: r = mk_seg(1'b0, T_GAP);
                        default: r = SEG_STOP;
                    endcase
                end
                default: r = SEG_STOP;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lps_led.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LED pattern sequencer: per-LED segment engine
// Holds one LED's pattern, segment and time base and advances them on
// tick and select requests.
// ---------------------------------------------------------------------------
module lps_led
    import lps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_led_cmd i_cmd,
    output logic          o_lit
);

    logic [3:0]           r_pat;
    logic [3:0]           n_pat;
    logic [SEG_W-1:0]     r_seg;
    logic [SEG_W-1:0]     n_seg;
    logic [15:0]          r_start;
    logic [15:0]          n_start;
    logic                 r_lit;
    logic                 n_lit;
    t_seg                 cur_seg;
    t_seg                 first_seg;
    t_seg                 next_seg;
    t_seg                 sel_seg;
    t_seg                 off_seg;
    logic [SEG_IDX_W-1:0] next_idx;
    logic [15:0]          elapsed;

    always_comb begin
        cur_seg   = seg_rom(r_pat, {1'b0, r_seg});
        first_seg = seg_rom(r_pat, '0);
        next_idx  = {1'b0, r_seg} + SEG_IDX_W'(1);
        next_seg  = seg_rom(r_pat, next_idx);
        sel_seg   = seg_rom(i_cmd.pattern, '0);
        off_seg   = seg_rom(PAT_OFF, '0);
        elapsed   = i_cmd.now - r_start;

        n_pat   = r_pat;
        n_seg   = r_seg;
        n_start = r_start;
        n_lit   = r_lit;

        if (i_cmd.tick && (first_seg.ticks != T_NONE) && (elapsed > cur_seg.ticks)) begin
            if ((next_seg.ticks == T_NONE) && !next_seg.on) begin
                if (r_pat != PAT_OFF) begin
                    n_pat   = PAT_OFF;
                    n_seg   = '0;
                    n_start = i_cmd.now;
                    n_lit   = off_seg.on;
                end
            end else if (next_seg.ticks == T_NONE) begin
                n_seg   = '0;
                n_start = r_start + cur_seg.ticks;
                n_lit   = first_seg.on;
            end else begin
                n_seg   = next_idx[SEG_W-1:0];
                n_start = r_start + cur_seg.ticks;
                n_lit   = next_seg.on;
            end
        end else if (i_cmd.sel && (i_cmd.pattern != r_pat)) begin
            n_pat   = i_cmd.pattern;
            n_seg   = '0;
            n_start = i_cmd.now;
            n_lit   = sel_seg.on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat   <= PAT_OFF;
            r_seg   <= '0;
            r_start <= '0;
            r_lit   <= 1'b0;
        end else begin
            r_pat   <= n_pat;
            r_seg   <= n_seg;
            r_start <= n_start;
            r_lit   <= n_lit;
        end
    end

    assign o_lit = n_lit;

endmodule
`default_nettype wire

[hw/rtl/lps_pwm.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LED pattern sequencer: PWM compare generator
// Holds the period register and dim flag and maps lit states to compares.
// ---------------------------------------------------------------------------
module lps_pwm
    import lps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_dim_wr,
    input  wire logic        i_dim,
    input  wire logic        i_lit0,
    input  wire logic        i_lit1,
    output logic      [15:0] o_cmp0,
    output logic      [15:0] o_cmp1
);

    logic [15:0] r_per;
    logic        r_dimmed;
    logic        n_dimmed;
    logic [20:0] per_x19;
    logic [18:0] per_q4;
    logic [38:0] div_prod;
    logic [15:0] dim_cmp;
    logic [15:0] off_cmp;
    logic [15:0] lit_cmp;

    // The dim compare is period * 19 / 20, taken as (period * 19 / 4) / 5.
    always_comb begin
        per_x19  = {1'b0, r_per, 4'b0} + {4'b0, r_per, 1'b0} + {5'b0, r_per};
        per_q4   = per_x19[20:2];
        div_prod = 39'(per_q4) * 39'(DIV5_RECIP);
        dim_cmp  = div_prod[37:22];
        off_cmp  = (r_per == CMP_MAX) ? CMP_MAX : r_per + 16'd1;
        n_dimmed = i_dim_wr ? i_dim : r_dimmed;
        lit_cmp  = n_dimmed ? dim_cmp : CMP_FULL_ON;
        o_cmp0   = i_lit0 ? lit_cmp : off_cmp;
        o_cmp1   = i_lit1 ? lit_cmp : off_cmp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per    <= PERIOD_RESET;
            r_dimmed <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_per <= i_cfg_data;
            end
            r_dimmed <= n_dimmed;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/led_pattern_sequencer.sv]
`default_nettype none
// An accepted request is held in the input registers until it can advance;
// its result is then captured in the result registers.
// Throughput: one request per cycle; the input and result registers form
// a two-stage pipeline that stalls its input only while a result is stalled.
// Reset: synchronous active-low; both LEDs off, full brightness, period 500.
// A period write applies to requests accepted at or after the write edge.
// ---------------------------------------------------------------------------
// LED pattern sequencer
// Two-LED blink pattern engine producing PWM compare values per request.
// ---------------------------------------------------------------------------
module led_pattern_sequencer
    import lps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_time_now,
    input  wire logic        i_led_index,
    input  wire logic [3:0]  i_pattern,
    input  wire logic        i_dim_request,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [15:0] o_led0_compare,
    output logic      [15:0] o_led1_compare,
    output logic             o_led0_lit,
    output logic             o_led1_lit,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic        r_in_vld;
    logic [1:0]  r_kind;
    logic [15:0] r_time;
    logic        r_led;
    logic [3:0]  r_pat;
    logic        r_dim;
    logic        r_out_vld;
    logic [15:0] r_cmp0;
    logic [15:0] r_cmp1;
    logic        r_lit0;
    logic        r_lit1;
    logic        adv;
    logic        fire;
    logic        load;
    t_led_cmd    cmd0;
    t_led_cmd    cmd1;
    logic        lit0;
    logic        lit1;
    logic [15:0] cmp0;
    logic [15:0] cmp1;

    assign adv        = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;
    assign load       = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cmd0.tick    = fire && (r_kind == KIND_TICK);
        cmd0.sel     = fire && (r_kind == KIND_SELECT) && !r_led;
        cmd0.pattern = r_pat;
        cmd0.now     = r_time;
        cmd1.tick    = cmd0.tick;
        cmd1.sel     = fire && (r_kind == KIND_SELECT) && r_led;
        cmd1.pattern = r_pat;
        cmd1.now     = r_time;
    end

    lps_led u_led0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd0),
        .o_lit   (lit0)
    );

    lps_led u_led1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd1),
        .o_lit   (lit1)
    );

    lps_pwm u_pwm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_dim_wr   (fire && (r_kind == KIND_DIM)),
        .i_dim      (r_dim),
        .i_lit0     (lit0),
        .i_lit1     (lit1),
        .o_cmp0     (cmp0),
        .o_cmp1     (cmp1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_kind;
            r_time <= i_time_now;
            r_led  <= i_led_index;
            r_pat  <= i_pattern;
            r_dim  <= i_dim_request;
        end
        if (fire) begin
            r_cmp0 <= cmp0;
            r_cmp1 <= cmp1;
            r_lit0 <= lit0;
            r_lit1 <= lit1;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_led0_compare = r_cmp0;
    assign o_led1_compare = r_cmp1;
    assign o_led0_lit     = r_lit0;
    assign o_led1_lit     = r_lit1;

endmodule
`default_nettype wire

[hw/rtl/lps_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// LED pattern sequencer port checker
// Watches the top-level ports and checks result consistency over time.
// ---------------------------------------------------------------------------
`include "led_pattern_sequencer_defines.svh"

module lps_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [15:0] o_led0_compare,
    input wire logic [15:0] o_led1_compare,
    input wire logic        o_led0_lit,
    input wire logic        o_led1_lit
);

    `LPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_led0_compare) && $stable(o_led1_compare) && $stable(o_led0_lit) && $stable(o_led1_lit))
    `LPS_ASSERT_IMPL(a_same_state_same_cmp, i_clk, i_rst_n, o_out_valid && (o_led0_lit == o_led1_lit), o_led0_compare == o_led1_compare)
    `LPS_ASSERT_IMPL(a_lit0_brighter, i_clk, i_rst_n, o_out_valid && o_led0_lit && !o_led1_lit, o_led0_compare < o_led1_compare)
    `LPS_ASSERT_IMPL(a_lit1_brighter, i_clk, i_rst_n, o_out_valid && o_led1_lit && !o_led0_lit, o_led1_compare < o_led0_compare)

endmodule

bind led_pattern_sequencer lps_checker u_lps_checker (.*);
`default_nettype wire

[tb/tb_led_pattern_sequencer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED pattern sequencer testbench
// Drives tick, select, dim and unused-kind requests with random idling on
// both sides and checks results against a cycle-free model of the blink
// engine. A short table of directed requests comes first, then phases of
// random well-formed time sequences, each under a different PWM period.
// ---------------------------------------------------------------------------
module tb_led_pattern_sequencer;
    import lps_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 222;

    typedef struct packed {
        logic [15:0] led0_compare;
        logic [15:0] led1_compare;
        logic        led0_lit;
        logic        led1_lit;
    } led_result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] now;
        logic        led;
        logic [3:0]  pat;
        logic        dim;
        logic        known;
        led_result_t want;
    } stim_row_t;

    typedef struct packed {
        logic        on;
        logic [15:0] ticks;
    } blink_seg_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = KIND_TICK;
    logic [15:0] i_time_now = '0;
    logic        i_led_index = 1'b0;
    logic [3:0]  i_pattern = PAT_OFF;
    logic        i_dim_request = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_led0_compare;
    logic [15:0] o_led1_compare;
    logic        o_led0_lit;
    logic        o_led1_lit;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    logic        row_known = 1'b0;
    led_result_t row_want = '0;

    logic        rom_on [16][PATTERN_SEGMENTS];
    logic [15:0] rom_ticks [16][PATTERN_SEGMENTS];

    logic [3:0]  led_pat [2] = '{PAT_OFF, PAT_OFF};
    logic [3:0]  led_segment [2] = '{4'd0, 4'd0};
    logic [15:0] led_start [2] = '{16'd0, 16'd0};
    logic        led_on [2] = '{1'b0, 1'b0};
    logic        dim_on = 1'b0;
    logic [15:0] period_cfg = PERIOD_RESET;

    led_result_t expected_results [$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int unsigned cycle_count = 0;
    int          sender_mode = 1;
    int          receiver_mode = 1;
    bit          hold_results = 1'b0;
    logic [15:0] tick_clock = '0;

    led_pattern_sequencer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_time_now     (i_time_now),
        .i_led_index    (i_led_index),
        .i_pattern      (i_pattern),
        .i_dim_request  (i_dim_request),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_led0_compare (o_led0_compare),
        .o_led1_compare (o_led1_compare),
        .o_led0_lit     (o_led0_lit),
        .o_led1_lit     (o_led1_lit),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        int n;
        for (int p = 0; p < 16; p++) begin
            for (int s = 0; s < PATTERN_SEGMENTS; s++) begin
                rom_on[p][s] = 1'b0;
                rom_ticks[p][s] = '0;
            end
        end
        rom_on[1][0] = 1'b1;
        for (int p = 2; p <= 4; p++) begin
            rom_on[p][0] = 1'b1;
            rom_ticks[p][0] = (p == 2) ? T_1HZ : (p == 3) ? T_2HZ : T_4HZ;
            rom_ticks[p][1] = rom_ticks[p][0];
            rom_on[p][2] = 1'b1;
        end
        rom_on[5][0] = 1'b1;
        rom_ticks[5][0] = T_BLIP;
        for (int p = 6; p <= 9; p++) begin
            n = p - 5;
            for (int k = 0; k < n; k++) begin
                rom_on[p][2 * k] = 1'b1;
                rom_ticks[p][2 * k] = T_BLIP;
                rom_ticks[p][2 * k + 1] = (k == n - 1) ? T_PAUSE : T_GAP;
            end
            rom_on[p][2 * n] = 1'b1;
        end
        for (int p = 10; p <= 13; p++) begin
            n = p - 9;
            for (int k = 0; k < n; k++) begin
                rom_on[p][2 * k] = 1'b1;
                rom_ticks[p][2 * k] = T_GAP;
                rom_ticks[p][2 * k + 1] = T_BOFF;
            end
            rom_on[p][2 * n] = 1'b1;
            rom_ticks[p][2 * n] = T_PAUSE;
            rom_on[p][2 * n + 1] = 1'b1;
        end
        rom_on[14][0] = 1'b1;
        rom_ticks[14][0] = T_BLIP;
        rom_ticks[14][1] = T_SLOW;
        rom_on[14][2] = 1'b1;
        for (int k = 0; k < 4; k++) begin
            rom_on[15][2 * k] = 1'b1;
            rom_ticks[15][2 * k] = T_BLIP;
            rom_ticks[15][2 * k + 1] = T_GAP;
        end
    end

    function automatic blink_seg_t rom_segment(logic [3:0] p, int s);
        blink_seg_t seg;
        seg = '0;
        if (s < PATTERN_SEGMENTS) begin
            seg.on = rom_on[p][s];
            seg.ticks = rom_ticks[p][s];
        end
        return seg;
    endfunction

    function automatic void start_pattern(int led, logic [3:0] p, logic [15:0] now);
        if (p != led_pat[led]) begin
            led_pat[led] = p;
            led_segment[led] = 4'd0;
            led_start[led] = now;
            led_on[led] = rom_on[p][0];
        end
    endfunction

    function automatic void advance_led(int led, logic [15:0] now);
        blink_seg_t first;
        blink_seg_t cur;
        blink_seg_t nxt;
        logic [3:0] p;
        logic [15:0] elapsed;
        int s;
        p = led_pat[led];
        s = led_segment[led];
        first = rom_segment(p, 0);
        cur = rom_segment(p, s);
        elapsed = now - led_start[led];
        if (first.ticks == 0 || elapsed <= cur.ticks)
            return;
        s++;
        nxt = rom_segment(p, s);
        if (nxt.ticks == 0 && !nxt.on) begin
            start_pattern(led, PAT_OFF, now);
            return;
        end
        if (nxt.ticks == 0)
            s = 0;
        nxt = rom_segment(p, s);
        led_segment[led] = s[3:0];
        led_start[led] = led_start[led] + cur.ticks;
        led_on[led] = nxt.on;
    endfunction

    function automatic logic [15:0] compare_value(logic on);
        logic [31:0] per;
        per = {16'd0, period_cfg};
        if (!on)
            return (per + 1 > 32'd65535) ? CMP_MAX : 16'(per + 1);
        if (dim_on)
            return 16'((per * 19) / 20);
        return CMP_FULL_ON;
    endfunction

    function automatic led_result_t predict_compares(logic [1:0] kind, logic [15:0] now,
                                                     logic led, logic [3:0] pat, logic dim);
        led_result_t res;
        case (kind)
            KIND_TICK: begin
                advance_led(0, now);
                advance_led(1, now);
            end
            KIND_SELECT: start_pattern(int'(led), pat, now);
            KIND_DIM: dim_on = dim;
            default: ;
        endcase
        res.led0_compare = compare_value(led_on[0]);
        res.led1_compare = compare_value(led_on[1]);
        res.led0_lit = led_on[0];
        res.led1_lit = led_on[1];
        return res;
    endfunction

    always @(posedge i_clk) begin
        led_result_t got;
        led_result_t want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                period_cfg = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                want = predict_compares(i_kind, i_time_now, i_led_index, i_pattern,
                                        i_dim_request);
                if (row_known)
                    want = row_want;
                expected_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{o_led0_compare, o_led1_compare, o_led0_lit, o_led1_lit};
                result_count++;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Result %0d arrived with no request outstanding.",
                                 result_count);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.led0_compare !== want.led0_compare ||
                        got.led1_compare !== want.led1_compare ||
                        got.led0_lit !== want.led0_lit ||
                        got.led1_lit !== want.led1_lit) begin
                        if (mismatch_count < 10)
                            $display("Result %0d mismatch: expected %0d %0d lit %b%b, got %0d %0d lit %b%b",
                                     result_count, want.led0_compare, want.led1_compare,
                                     want.led0_lit, want.led1_lit, got.led0_compare,
                                     got.led1_compare, got.led0_lit, got.led1_lit);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_cycles(int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
        endcase
    endfunction

    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                n = HOLD_CYCLES;
                hold_results = 1'b0;
            end else begin
                n = idle_cycles(receiver_mode);
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    function automatic stim_row_t make_row(logic [1:0] kind, logic [15:0] now, logic led,
                                           logic [3:0] pat, logic dim);
        stim_row_t r;
        r = '0;
        r.kind = kind;
        r.now = now;
        r.led = led;
        r.pat = pat;
        r.dim = dim;
        return r;
    endfunction

    function automatic stim_row_t known_row(logic [1:0] kind, logic [15:0] now, logic led,
                                            logic [3:0] pat, logic dim, logic [15:0] c0,
                                            logic [15:0] c1, logic l0, logic l1);
        stim_row_t r;
        r = make_row(kind, now, led, pat, dim);
        r.known = 1'b1;
        r.want = '{c0, c1, l0, l1};
        return r;
    endfunction

    task automatic send_request(input stim_row_t r);
        int gap;
        gap = idle_cycles(sender_mode);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind <= r.kind;
        i_time_now <= r.now;
        i_led_index <= r.led;
        i_pattern <= r.pat;
        i_dim_request <= r.dim;
        row_known <= r.known;
        row_want <= r.want;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int count, input bit pause_midway);
        stim_row_t r;
        int roll;
        int pick;
        logic [15:0] step;
        for (int i = 0; i < count; i++) begin
            r = make_row(KIND_TICK, 16'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    step = 16'($urandom_range(0, 30));
                else if (pick < 16)
                    step = 16'($urandom_range(0, 250));
                else if (pick < 19)
                    step = 16'($urandom_range(0, 1600));
                else
                    step = 16'($urandom_range(0, 6000));
                tick_clock = tick_clock + step;
                r.now = tick_clock;
            end else if (roll < 80) begin
                r.kind = KIND_SELECT;
                r.now = tick_clock;
            end else if (roll < 90) begin
                r.kind = KIND_DIM;
            end else if (roll < 95) begin
                r.kind = KIND_UNUSED;
            end else if ($urandom_range(0, 1) == 1) begin
                tick_clock = r.now;
            end
            send_request(r);
            if (pause_midway && i == count / 2)
                drain_results();
        end
    endtask

    initial begin
        stim_row_t rows [$];
        logic [15:0] periods [PHASES];
        periods = '{16'd2, 16'd65535, 16'd65534, 16'd0, 16'd1, PERIOD_RESET,
                    16'($urandom), 16'($urandom_range(2, 1000))};

        rows.push_back(known_row(KIND_TICK, 16'd0, 1'b0, PAT_OFF, 1'b0,
                                 OFF_RESET, OFF_RESET, 1'b0, 1'b0));
        rows.push_back(known_row(KIND_UNUSED, 16'hFFFF, 1'b1, 4'd15, 1'b1,
                                 OFF_RESET, OFF_RESET, 1'b0, 1'b0));
        rows.push_back(known_row(KIND_DIM, 16'd0, 1'b0, PAT_OFF, 1'b1,
                                 OFF_RESET, OFF_RESET, 1'b0, 1'b0));
        rows.push_back(known_row(KIND_SELECT, 16'd100, 1'b0, 4'd1, 1'b0,
                                 DIM_RESET, OFF_RESET, 1'b1, 1'b0));
        rows.push_back(known_row(KIND_DIM, 16'd100, 1'b0, PAT_OFF, 1'b0,
                                 CMP_FULL_ON, OFF_RESET, 1'b1, 1'b0));
        rows.push_back(known_row(KIND_SELECT, 16'd100, 1'b1, 4'd1, 1'b0,
                                 CMP_FULL_ON, CMP_FULL_ON, 1'b1, 1'b1));
        rows.push_back(known_row(KIND_SELECT, 16'd200, 1'b1, 4'd1, 1'b0,
                                 CMP_FULL_ON, CMP_FULL_ON, 1'b1, 1'b1));
        rows.push_back(known_row(KIND_SELECT, 16'd300, 1'b0, PAT_OFF, 1'b0,
                                 OFF_RESET, CMP_FULL_ON, 1'b0, 1'b1));
        rows.push_back(make_row(KIND_SELECT, 16'd1000, 1'b1, 4'd2, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd1500, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd1501, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_SELECT, 16'd2000, 1'b0, 4'd5, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd2021, 1'b1, 4'd15, 1'b1));
        rows.push_back(make_row(KIND_SELECT, 16'd65500, 1'b1, 4'd15, 1'b0));
        rows.push_back(make_row(KIND_SELECT, 16'd65500, 1'b0, 4'd14, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd65521, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd185, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_DIM, 16'd185, 1'b0, PAT_OFF, 1'b1));
        rows.push_back(make_row(KIND_TICK, 16'hFFFF, 1'b1, 4'd15, 1'b1));
        rows.push_back(make_row(KIND_SELECT, 16'd0, 1'b0, 4'd13, 1'b0));
        rows.push_back(make_row(KIND_SELECT, 16'd0, 1'b1, 4'd10, 1'b0));
        rows.push_back(make_row(KIND_TICK, 16'd201, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_UNUSED, 16'd0, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_DIM, 16'd201, 1'b0, PAT_OFF, 1'b0));
        rows.push_back(make_row(KIND_SELECT, 16'd201, 1'b1, 4'd4, 1'b1));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i])
            send_request(rows[i]);
        tick_clock = 16'd201;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_period(periods[ph]);
            sender_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
            receiver_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
            if (ph == 2)
                hold_results = 1'b1;
            run_random_phase(PHASE_ITEMS, ph == 3);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/lps_led.sv
hw/rtl/lps_pwm.sv
hw/rtl/led_pattern_sequencer.sv
hw/rtl/lps_checker.sv
tb/tb_led_pattern_sequencer.sv
